### hw/rtl/b2oc_pkg.sv
// Shared types and constants of the 2x2 opening check block.
package b2oc_pkg;

  // Widths fixed by the register map and the result word
  localparam int unsigned DIM_W   = 7;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned COUNT_W = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_ROWS = 1'b0,
    REG_IMAGE_COLS = 1'b1
  } cfg_reg_e;

  // Result word kinds
  typedef enum logic {
    KIND_STAMP   = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  // One result word
  typedef struct packed {
    kind_e              kind;
    logic [POS_W-1:0]   stamp_row;
    logic [POS_W-1:0]   stamp_col;
    logic               reconstructible;
    logic [COUNT_W-1:0] stamp_count;
    logic               last;
  } result_t;

endpackage

### hw/rtl/binary_2x2_opening_check_core.sv
// Top level of the streaming 2x2 binary opening check.
//
// Pixels enter in raster order, and the block sustains one pixel per clock while the
// resolve stage is not stalled by a full output queue. A pixel is registered on acceptance
// while its line-buffer words are read (above and above-right), and it is resolved in the
// resolve stage. Its results are registered in a two-word output queue that feeds the output.
// A pixel that yields both a stamp and the verdict waits until the queue is empty. The line
// buffer is one MAX_DIM x 2-bit synchronous memory that holds a pixel and a stamp flag per
// column. It has one write port and two read ports, with a bypass for a word still being
// written. Fill counts mark which entries hold live data, so no clearing pass runs after
// reset or between images. Image sizes are read on every pixel. Zero counts as one and
// values above MAX_DIM count as MAX_DIM.
module binary_2x2_opening_check_core
  import b2oc_pkg::*;
#(
  parameter int unsigned MAX_DIM = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  // pixel channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 pixel_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 kind_o,
  output logic [POS_W-1:0]     stamp_row_o,
  output logic [POS_W-1:0]     stamp_col_o,
  output logic                 reconstructible_o,
  output logic [COUNT_W-1:0]   stamp_count_o,
  output logic                 last_o
);

  localparam int unsigned CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned NW = CW + 1;
  localparam int unsigned DW = (NW > DIM_W) ? NW : DIM_W;

  // Resolve-stage word
  typedef struct packed {
    logic          pix;
    logic [CW-1:0] row;
    logic [CW-1:0] col;
    logic          row_end;
    logic          image_end;
    logic          last_row;
    logic          up_ok;
    logic          cov_a_ok;
    logic          cov_b_ok;
    logic          fwd_a;
    logic          fwd_b;
  } s1_t;

  // Configuration registers
  logic [DIM_W-1:0] rows_cfg_q, cols_cfg_q;

  // Position counters and fill counts
  logic [CW-1:0] row_q, row_d, col_q, col_d;
  logic [NW-1:0] hwm_q, hwm_d, plen_q, plen_d;

  // Resolve stage
  logic          s1_valid_q;
  s1_t           s1_q;
  logic          s1_fire;

  // Line buffer: bit 1 pixel, bit 0 stamp found at that column
  logic [1:0]    line_mem [MAX_DIM];
  logic [1:0]    rd_a_q, rd_b_q, fwd_word_q;
  logic [CW-1:0] addr_b;
  logic [1:0]    wr_word;

  // Row context
  logic          left_q, diag_q, dcov_q, last_stamp_q, mism_q;
  logic [COUNT_W-1:0] cnt_q;

  // Output queue
  result_t       oq_q [2];
  logic          oq_wr_q, oq_rd_q;
  logic [1:0]    oq_cnt_q;

  logic          accept;
  logic [DW-1:0] rows_eff, cols_eff, col_p1_w, row_p1_w;
  logic [NW-1:0] col_p1;
  logic          row_end, last_row, image_end;

  // Configuration writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= DIM_W'(64);
      cols_cfg_q <= DIM_W'(64);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_ROWS: rows_cfg_q <= cfg_data_i;
        REG_IMAGE_COLS: cols_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp sizes and find row and image ends of the incoming pixel
  always_comb begin
    rows_eff = DW'(rows_cfg_q);
    cols_eff = DW'(cols_cfg_q);
    if (rows_eff == '0) begin
      rows_eff = DW'(1);
    end else if (rows_eff > DW'(MAX_DIM)) begin
      rows_eff = DW'(MAX_DIM);
    end
    if (cols_eff == '0) begin
      cols_eff = DW'(1);
    end else if (cols_eff > DW'(MAX_DIM)) begin
      cols_eff = DW'(MAX_DIM);
    end
    col_p1_w  = DW'(col_q) + DW'(1);
    row_p1_w  = DW'(row_q) + DW'(1);
    col_p1    = NW'(col_q) + NW'(1);
    row_end   = (col_p1_w >= cols_eff);
    last_row  = (row_p1_w >= rows_eff);
    image_end = row_end && last_row;
  end

  assign accept = in_valid_i && in_ready_o;
  assign addr_b = col_q + CW'(1);

  // Advance position and fill counts
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    hwm_d  = hwm_q;
    plen_d = plen_q;
    if (accept) begin
      if (image_end) begin
        col_d  = '0;
        row_d  = '0;
        hwm_d  = '0;
        plen_d = '0;
      end else begin
        if (col_p1 > hwm_q) begin
          hwm_d = col_p1;
        end
        if (row_end) begin
          col_d  = '0;
          row_d  = row_q + CW'(1);
          plen_d = col_p1;
        end else begin
          col_d = CW'(col_p1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      hwm_q  <= '0;
      plen_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      hwm_q  <= hwm_d;
      plen_q <= plen_d;
    end
  end

  // Resolve stage: memory data, row context, checks
  logic          c0, up, s_a, s_b, upc, stamp;
  logic          left_eff, diag_eff, dcov_eff, lst_eff, dcov2;
  logic          mism_new;
  logic [COUNT_W-1:0] cnt_new;
  logic [1:0]    word_a, word_b;
  logic [1:0]    n_push, oq_space;

  always_comb begin
    word_a   = s1_q.fwd_a ? fwd_word_q : rd_a_q;
    word_b   = s1_q.fwd_b ? fwd_word_q : rd_b_q;
    c0       = (s1_q.col == '0);
    up       = s1_q.up_ok && word_a[1];
    s_a      = s1_q.cov_a_ok && word_a[0];
    s_b      = s1_q.cov_b_ok && word_b[0];
    left_eff = !c0 && left_q;
    diag_eff = !c0 && diag_q;
    dcov_eff = !c0 && dcov_q;
    lst_eff  = !c0 && last_stamp_q;
    stamp    = (s1_q.row != '0) && !c0 && diag_eff && up && left_eff && s1_q.pix;
    dcov2    = dcov_eff || stamp;
    upc      = s_a || s_b || stamp;
    mism_new = mism_q;
    // above-left pixel is final once its right neighbour is passed
    if ((s1_q.row != '0) && !c0 && (diag_eff != dcov2)) begin
      mism_new = 1'b1;
    end
    // above pixel at the row end
    if ((s1_q.row != '0) && s1_q.row_end && (up != upc)) begin
      mism_new = 1'b1;
    end
    // bottom row pixels are final as they pass
    if (s1_q.last_row && !c0 && (left_eff != (lst_eff || stamp))) begin
      mism_new = 1'b1;
    end
    if (s1_q.last_row && s1_q.row_end && (s1_q.pix != stamp)) begin
      mism_new = 1'b1;
    end
    cnt_new = cnt_q;
    if (stamp && (cnt_q != COUNT_MAX)) begin
      cnt_new = cnt_q + COUNT_W'(1);
    end
    n_push   = {1'b0, stamp} + {1'b0, s1_q.image_end};
    oq_space = 2'd2 - oq_cnt_q;
    wr_word  = {s1_q.pix, stamp};
  end

  assign s1_fire    = s1_valid_q && (n_push <= oq_space);
  assign in_ready_o = !s1_valid_q || s1_fire;

  // Capture the pixel and its read context
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.pix       <= pixel_i;
      s1_q.row       <= row_q;
      s1_q.col       <= col_q;
      s1_q.row_end   <= row_end;
      s1_q.image_end <= image_end;
      s1_q.last_row  <= last_row;
      s1_q.up_ok     <= (row_q != '0) && (NW'(col_q) < hwm_q);
      s1_q.cov_a_ok  <= (row_q != '0) && (NW'(col_q) < plen_q);
      s1_q.cov_b_ok  <= (row_q != '0) && (col_p1 < plen_q);
      // bypass the word written in this same cycle
      s1_q.fwd_a     <= s1_fire && (s1_q.col == col_q);
      s1_q.fwd_b     <= s1_fire && (NW'(s1_q.col) == col_p1);
      fwd_word_q     <= wr_word;
    end
  end

  // Line buffer ports
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_mem[s1_q.col] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_a_q <= line_mem[col_q];
      rd_b_q <= line_mem[addr_b];
    end
  end

  // Hold row context and image totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= 1'b0;
      diag_q       <= 1'b0;
      dcov_q       <= 1'b0;
      last_stamp_q <= 1'b0;
      mism_q       <= 1'b0;
      cnt_q        <= '0;
    end else if (s1_fire) begin
      left_q       <= s1_q.pix;
      diag_q       <= up;
      dcov_q       <= upc;
      last_stamp_q <= stamp;
      if (s1_q.image_end) begin
        mism_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        mism_q <= mism_new;
        cnt_q  <= cnt_new;
      end
    end
  end

  // Output queue: stamp word first, verdict after
  result_t stamp_res, verdict_res, first_res;
  logic    pop;

  always_comb begin
    stamp_res                 = '0;
    stamp_res.kind            = KIND_STAMP;
    stamp_res.stamp_row       = POS_W'(s1_q.row);
    stamp_res.stamp_col       = POS_W'(s1_q.col);
    verdict_res               = '0;
    verdict_res.kind          = KIND_VERDICT;
    verdict_res.reconstructible = !mism_new;
    verdict_res.stamp_count   = cnt_new;
    verdict_res.last          = 1'b1;
    first_res                 = stamp ? stamp_res : verdict_res;
  end

  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (s1_fire && (n_push != 2'd0)) begin
      oq_q[oq_wr_q] <= first_res;
      if (n_push == 2'd2) begin
        oq_q[!oq_wr_q] <= verdict_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= '0;
    end else begin
      if (s1_fire) begin
        oq_wr_q <= oq_wr_q ^ n_push[0];
      end
      if (pop) begin
        oq_rd_q <= !oq_rd_q;
      end
      oq_cnt_q <= oq_cnt_q + (s1_fire ? n_push : 2'd0) - {1'b0, pop};
    end
  end

  // Drive the result word
  result_t head;
  assign head              = oq_q[oq_rd_q];
  assign out_valid_o       = (oq_cnt_q != '0);
  assign kind_o            = head.kind;
  assign stamp_row_o       = head.stamp_row;
  assign stamp_col_o       = head.stamp_col;
  assign reconstructible_o = head.reconstructible;
  assign stamp_count_o     = head.stamp_count;
  assign last_o            = head.last;

endmodule
